/* design/dwdc_pkg.sv */
// ----------------------------------------------------------------------------
// dwdc_pkg
// shared constants for the dual word to double converter
// ----------------------------------------------------------------------------
package dwdc_pkg;
    localparam int unsigned WORD_W = 24;
    localparam int unsigned MAG_W  = 48;
    localparam int unsigned POS_W  = 6;
    localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
    localparam logic [12:0] EXP_OFFSET = 13'd2082;

    typedef enum logic [0:0] {
        KIND_FIXED = 1'b0,
        KIND_FLOAT = 1'b1
    } t_kind;

    // stage 1 -> stage 2 payload
    typedef struct packed {
        logic              sign;
        logic              force_zero;
        logic              force_inf;
        logic [MAG_W-1:0]  mag;
        logic signed [13:0] exp;
    } t_s1;
endpackage

/* design/dual_word_to_double_converter.sv */
// ----------------------------------------------------------------------------
// dual_word_to_double_converter
// converts a 24-bit word pair (fixed or mantissa/exponent) to a binary64 pattern
// ----------------------------------------------------------------------------
// one transaction per cycle through the three stages:
// magnitude/exponent, leading one search, pack
// busy is always low; o_valid pulses one cycle per result
// synchronous active low reset clears the stage valid bits only
module dual_word_to_double_converter
    import dwdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [23:0] i_low_word,
    input  logic [23:0] i_high_word,
    output logic        o_valid,
    output logic [63:0] o_value_bits
);
    logic r_v1, r_v2, r_v3;
    t_s1  r_s1, n_s1;
    t_s1  r_s2;
    logic [POS_W-1:0] r_pos2, n_pos2;
    logic [63:0] r_out, n_out;

    assign busy = 1'b0;

    // stage 1: magnitude and exponent
    always_comb begin
        logic [47:0]        raw;
        logic signed [13:0] e;
        raw = {i_high_word, i_low_word};
        e   = $signed({2'b00, i_high_word[23:12]}) - $signed({1'b0, EXP_OFFSET});
        n_s1 = '0;
        if (i_kind == KIND_FIXED) begin
            n_s1.sign = i_high_word[23];
            n_s1.mag  = i_high_word[23] ? (48'd0 - raw) : raw;
            n_s1.exp  = '0;
            n_s1.force_zero = (raw == 48'd0);
        end else begin
            n_s1.mag  = {12'd0, i_high_word[11:0], i_low_word};
            n_s1.exp  = e;
            n_s1.force_zero = (n_s1.mag == 48'd0) || (e < -14'sd1074);
            n_s1.force_inf  = (n_s1.mag != 48'd0) && (e > 14'sd1023);
        end
    end

    // stage 2: leading one position
    always_comb begin
        n_pos2 = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (r_s1.mag[i]) n_pos2 = POS_W'(i);
        end
    end

    // stage 3: pack the fields
    always_comb begin
        logic signed [13:0] big_e;
        logic [63:0]        m64;
        logic [5:0]         sh;
        m64   = {16'd0, r_s2.mag};
        big_e = $signed({8'd0, r_pos2}) + r_s2.exp;
        sh    = 6'(7'd52 - {1'b0, r_pos2});
        if (r_s2.force_zero) begin
            n_out = '0;
        end else if (r_s2.force_inf || big_e > 14'sd1023) begin
            n_out = POS_INF;
        end else if (big_e >= -14'sd1022) begin
            n_out = {r_s2.sign, 11'(big_e + 14'sd1023), 52'((m64 << sh))};
        end else begin
            n_out = m64 << 6'(r_s2.exp + 14'sd1074);
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= r_s1;
        r_pos2 <= n_pos2;
        r_out <= n_out;
    end

    assign o_valid      = r_v3;
    assign o_value_bits = r_out;

    // a started transaction appears at o_valid after passing r_v1, r_v2 and r_v3
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##3 o_valid) else $error("result lost");
    a_nostray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(start, 3)) else $error("stray result");
    a_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_s2.force_inf && !r_s2.force_zero |=> o_value_bits == POS_INF)
        else $error("overflow not infinity");
endmodule
